>>> design/aabb_accumulator_core_macros.svh
// Assertion macros shared by the accumulator core.
// Each expects clk and rst_n in scope.
`ifndef AABB_ACCUMULATOR_CORE_MACROS_SVH
`define AABB_ACCUMULATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AABB_CHECK_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aabb_accumulator_core: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define AABB_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aabb_accumulator_core: next-cycle check failed");

`endif

>>> design/aabb_pkg.sv
`timescale 1ns / 1ps

package aabb_pkg;

    localparam int COORD_BITS  = 32;
    localparam int NORMAL_BITS = 16;
    localparam int RADIUS_BITS = COORD_BITS - 1;
    localparam int NFRAC       = NORMAL_BITS - 1;
    // 1 - n^2 in Q1.(2*NFRAC); the value 1.0 itself must fit.
    localparam int FACTOR_BITS = 2 * NFRAC + 1;
    localparam int PROD_BITS   = RADIUS_BITS + FACTOR_BITS;
    localparam int EXT_BITS    = COORD_BITS + 2;
    localparam int AXES        = 3;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

    typedef logic [2:0] cmd_t;
    localparam cmd_t CMD_POINT  = 3'd0;
    localparam cmd_t CMD_SPHERE = 3'd1;
    localparam cmd_t CMD_MERGE  = 3'd2;
    localparam cmd_t CMD_DISK   = 3'd3;
    localparam cmd_t CMD_CLEAR  = 3'd4;

    typedef logic [1:0] op_t;
    localparam op_t OP_KEEP  = 2'd0;
    localparam op_t OP_WIDEN = 2'd1;
    localparam op_t OP_CLEAR = 2'd2;

    typedef logic [1:0] axis_t;
    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    typedef logic signed [COORD_BITS-1:0]   coord_t;
    typedef logic [AXES-1:0][COORD_BITS-1:0]  coord3_t;
    typedef logic [AXES-1:0][NORMAL_BITS-1:0] norm3_t;
    typedef logic [AXES-1:0][FACTOR_BITS-1:0] factor3_t;
    typedef logic [AXES-1:0][PROD_BITS-1:0]   prod3_t;

    localparam logic [FACTOR_BITS-1:0] FACTOR_ONE = {1'b1, {(2 * NFRAC){1'b0}}};

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};
    localparam logic signed [EXT_BITS-1:0] EXT_MAX = {3'b000, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [EXT_BITS-1:0] EXT_MIN = {3'b111, {(COORD_BITS - 1){1'b0}}};

    // One box update request passed from the front end to the back end.
    typedef struct packed {
        op_t     op;
        coord3_t lo;
        coord3_t hi;
    } aabb_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } aabb_q_stat_t;

endpackage

>>> design/aabb_item_if.sv
`timescale 1ns / 1ps

interface aabb_item_if
    import aabb_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic [2:0]                    command;
    logic signed [COORD_BITS-1:0]  pos_x;
    logic signed [COORD_BITS-1:0]  pos_y;
    logic signed [COORD_BITS-1:0]  pos_z;
    logic [RADIUS_BITS-1:0]        radius;
    logic signed [COORD_BITS-1:0]  upper_x;
    logic signed [COORD_BITS-1:0]  upper_y;
    logic signed [COORD_BITS-1:0]  upper_z;
    logic signed [NORMAL_BITS-1:0] normal_x;
    logic signed [NORMAL_BITS-1:0] normal_y;
    logic signed [NORMAL_BITS-1:0] normal_z;

    modport source (
        output valid, command, pos_x, pos_y, pos_z, radius,
               upper_x, upper_y, upper_z, normal_x, normal_y, normal_z,
        input  ready
    );

    modport sink (
        input  valid, command, pos_x, pos_y, pos_z, radius,
               upper_x, upper_y, upper_z, normal_x, normal_y, normal_z,
        output ready
    );
endinterface

>>> design/aabb_result_if.sv
`timescale 1ns / 1ps

interface aabb_result_if
    import aabb_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] box_min_x;
    logic signed [COORD_BITS-1:0] box_min_y;
    logic signed [COORD_BITS-1:0] box_min_z;
    logic signed [COORD_BITS-1:0] box_max_x;
    logic signed [COORD_BITS-1:0] box_max_y;
    logic signed [COORD_BITS-1:0] box_max_z;
    logic                         box_valid;
    logic [1:0]                   longest_axis;
    logic [1:0]                   shortest_axis;

    modport source (
        output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
               box_valid, longest_axis, shortest_axis,
        input  ready
    );

    modport sink (
        input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
               box_valid, longest_axis, shortest_axis,
        output ready
    );
endinterface

>>> design/aabb_front.sv
`timescale 1ns / 1ps

module aabb_front
    import aabb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    aabb_item_if.sink    item,
    input  aabb_q_stat_t q_stat,
    output logic         push,
    output aabb_req_t    push_data
);

    // Stage 1: captured item. Stage 2: disk factors. Stage 3: products.
    logic         s1_valid_reg;
    cmd_t         s1_cmd_reg;
    coord3_t      s1_pos_reg;
    coord3_t      s1_upper_reg;
    logic [RADIUS_BITS-1:0] s1_rad_reg;
    norm3_t       s1_norm_reg;

    logic         s2_valid_reg;
    cmd_t         s2_cmd_reg;
    coord3_t      s2_pos_reg;
    coord3_t      s2_upper_reg;
    logic [RADIUS_BITS-1:0] s2_rad_reg;
    factor3_t     s2_fac_reg;

    logic         s3_valid_reg;
    cmd_t         s3_cmd_reg;
    coord3_t      s3_pos_reg;
    coord3_t      s3_upper_reg;
    logic [RADIUS_BITS-1:0] s3_rad_reg;
    prod3_t       s3_prod_reg;

    logic s1_free;
    logic s2_free;
    logic s3_free;

    logic [NORMAL_BITS-1:0]   mag   [AXES];
    logic [2*NORMAL_BITS-1:0] sq    [AXES];
    factor3_t                 fac;
    prod3_t                   prod;

    logic [RADIUS_BITS-1:0]      half [AXES];
    logic signed [EXT_BITS-1:0]  p_ext [AXES];
    logic signed [EXT_BITS-1:0]  h_ext [AXES];
    logic signed [EXT_BITS-1:0]  sum   [AXES];
    logic signed [EXT_BITS-1:0]  diff  [AXES];
    coord3_t                     ball_lo;
    coord3_t                     ball_hi;
    logic                        merge_ok;

    assign s3_free    = !s3_valid_reg || !q_stat.full;
    assign s2_free    = !s2_valid_reg || s3_free;
    assign s1_free    = !s1_valid_reg || s2_free;
    assign item.ready = s1_free;
    assign push       = s3_valid_reg && !q_stat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= item.valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && item.valid)
        begin
            s1_cmd_reg   <= item.command;
            s1_pos_reg   <= {item.pos_z, item.pos_y, item.pos_x};
            s1_upper_reg <= {item.upper_z, item.upper_y, item.upper_x};
            s1_rad_reg   <= item.radius;
            s1_norm_reg  <= {item.normal_z, item.normal_y, item.normal_x};
        end
        if (s2_free && s1_valid_reg)
        begin
            s2_cmd_reg   <= s1_cmd_reg;
            s2_pos_reg   <= s1_pos_reg;
            s2_upper_reg <= s1_upper_reg;
            s2_rad_reg   <= s1_rad_reg;
            s2_fac_reg   <= fac;
        end
        if (s3_free && s2_valid_reg)
        begin
            s3_cmd_reg   <= s2_cmd_reg;
            s3_pos_reg   <= s2_pos_reg;
            s3_upper_reg <= s2_upper_reg;
            s3_rad_reg   <= s2_rad_reg;
            s3_prod_reg  <= prod;
        end
    end

    // The magnitude of the most negative normal is one, which still fits unsigned.
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            mag[a] = s1_norm_reg[a][NORMAL_BITS-1] ? (~s1_norm_reg[a] + NORMAL_BITS'(1))
                                                   : s1_norm_reg[a];
            sq[a]  = mag[a] * mag[a];
            fac[a] = FACTOR_ONE - sq[a][FACTOR_BITS-1:0];
        end
    end

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            prod[a] = {{FACTOR_BITS{1'b0}}, s2_rad_reg} * {{RADIUS_BITS{1'b0}}, s2_fac_reg[a]};
        end
    end

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            half[a]  = (s3_cmd_reg == CMD_SPHERE) ? s3_rad_reg
                                                  : s3_prod_reg[a][2*NFRAC +: RADIUS_BITS];
            p_ext[a] = {{2{s3_pos_reg[a][COORD_BITS-1]}}, s3_pos_reg[a]};
            h_ext[a] = {3'b000, half[a]};
            sum[a]   = p_ext[a] + h_ext[a];
            diff[a]  = p_ext[a] - h_ext[a];
            ball_hi[a] = (sum[a] > EXT_MAX)  ? COORD_MAX : sum[a][COORD_BITS-1:0];
            ball_lo[a] = (diff[a] < EXT_MIN) ? COORD_MIN : diff[a][COORD_BITS-1:0];
        end
        merge_ok = ($signed(s3_pos_reg[0]) <= $signed(s3_upper_reg[0]))
                && ($signed(s3_pos_reg[1]) <= $signed(s3_upper_reg[1]))
                && ($signed(s3_pos_reg[2]) <= $signed(s3_upper_reg[2]));
    end

    always_comb
    begin
        push_data.lo = s3_pos_reg;
        push_data.hi = s3_pos_reg;
        unique case (s3_cmd_reg)
            CMD_POINT:
            begin
                push_data.op = OP_WIDEN;
            end
            CMD_SPHERE, CMD_DISK:
            begin
                push_data.op = OP_WIDEN;
                push_data.lo = ball_lo;
                push_data.hi = ball_hi;
            end
            CMD_MERGE:
            begin
                push_data.op = merge_ok ? OP_WIDEN : OP_KEEP;
                push_data.hi = s3_upper_reg;
            end
            CMD_CLEAR:
            begin
                push_data.op = OP_CLEAR;
            end
            default:
            begin
                push_data.op = OP_KEEP;
            end
        endcase
    end

endmodule

>>> design/aabb_queue.sv
`timescale 1ns / 1ps

module aabb_queue
    import aabb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  aabb_req_t    push_data,
    input  logic         pop,
    output aabb_req_t    pop_data,
    output aabb_q_stat_t q_stat
);

    aabb_req_t              entry_reg [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]  wr_ptr_reg;
    logic [Q_PTR_BITS-1:0]  rd_ptr_reg;
    logic [Q_CNT_BITS-1:0]  count_reg;
    logic [Q_CNT_BITS-1:0]  count_next;

    assign q_stat.full  = (count_reg == Q_CNT_BITS'(Q_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + Q_CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/aabb_back.sv
`timescale 1ns / 1ps

module aabb_back
    import aabb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  aabb_q_stat_t q_stat,
    input  aabb_req_t    pop_data,
    output logic         pop,
    aabb_result_if.source result
);

    coord3_t box_lo_reg;
    coord3_t box_hi_reg;
    logic    holds_reg;
    // Set while the box registers hold an update whose result is not yet registered.
    logic    pend_reg;

    logic    out_valid_reg;
    coord3_t out_lo_reg;
    coord3_t out_hi_reg;
    logic    out_holds_reg;
    axis_t   out_long_reg;
    axis_t   out_short_reg;

    logic    out_load;
    logic [COORD_BITS-1:0] ext [AXES];
    axis_t   longest;
    axis_t   shortest;

    assign out_load = pend_reg && (!out_valid_reg || result.ready);
    assign pop      = !q_stat.empty && (!pend_reg || out_load);

    // Extents are never negative, so the difference is exact as unsigned.
    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            ext[a] = box_hi_reg[a] - box_lo_reg[a];
        end
        longest  = (ext[0] > ext[1]) ? ((ext[0] > ext[2]) ? AXIS_X
                                       : ((ext[1] > ext[2]) ? AXIS_Y : AXIS_Z))
                                     : ((ext[1] > ext[2]) ? AXIS_Y : AXIS_Z);
        shortest = (ext[0] < ext[1]) ? ((ext[0] < ext[2]) ? AXIS_X
                                       : ((ext[1] < ext[2]) ? AXIS_Y : AXIS_Z))
                                     : ((ext[1] < ext[2]) ? AXIS_Y : AXIS_Z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_lo_reg    <= '0;
            box_hi_reg    <= '0;
            holds_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                pend_reg <= 1'b1;
            end
            else if (out_load)
            begin
                pend_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (pop)
            begin
                unique case (pop_data.op)
                    OP_WIDEN:
                    begin
                        for (int a = 0; a < AXES; a++)
                        begin
                            if (!holds_reg || ($signed(pop_data.lo[a]) < $signed(box_lo_reg[a])))
                            begin
                                box_lo_reg[a] <= pop_data.lo[a];
                            end
                            if (!holds_reg || ($signed(pop_data.hi[a]) > $signed(box_hi_reg[a])))
                            begin
                                box_hi_reg[a] <= pop_data.hi[a];
                            end
                        end
                        holds_reg <= 1'b1;
                    end
                    OP_CLEAR:
                    begin
                        box_lo_reg <= '0;
                        box_hi_reg <= '0;
                        holds_reg  <= 1'b0;
                    end
                    OP_KEEP:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_lo_reg    <= box_lo_reg;
            out_hi_reg    <= box_hi_reg;
            out_holds_reg <= holds_reg;
            out_long_reg  <= longest;
            out_short_reg <= shortest;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.box_min_x     = out_lo_reg[0];
    assign result.box_min_y     = out_lo_reg[1];
    assign result.box_min_z     = out_lo_reg[2];
    assign result.box_max_x     = out_hi_reg[0];
    assign result.box_max_y     = out_hi_reg[1];
    assign result.box_max_z     = out_hi_reg[2];
    assign result.box_valid     = out_holds_reg;
    assign result.longest_axis  = out_long_reg;
    assign result.shortest_axis = out_short_reg;

endmodule

>>> design/aabb_accumulator_core.sv
// An accepted transaction passes through two more front stages, the request queue, the box
// registers and the output register before its result is valid, when nothing stalls.
// Throughput: one transaction per cycle while results are taken; one box compare-select per cycle.
// A four-entry request queue lets the front and back stall independently.
// Reset (rst_n low, asynchronous) empties the box: corners zero, its valid flag low, no results pending.
`timescale 1ns / 1ps
`include "aabb_accumulator_core_macros.svh"

module aabb_accumulator_core
    import aabb_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    aabb_item_if.sink     item,
    aabb_result_if.source result
);

    logic         push;
    aabb_req_t    push_data;
    logic         pop;
    aabb_req_t    pop_data;
    aabb_q_stat_t q_stat;
    logic         out_box_zero;
    logic         out_box_ordered;

    aabb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    aabb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    aabb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .pop_data (pop_data),
        .pop      (pop),
        .result   (result)
    );

    assign out_box_zero = (result.box_min_x == '0) && (result.box_max_x == '0)
                       && (result.box_min_y == '0) && (result.box_max_y == '0)
                       && (result.box_min_z == '0) && (result.box_max_z == '0)
                       && (result.longest_axis == AXIS_Z) && (result.shortest_axis == AXIS_Z);

    assign out_box_ordered = (result.box_min_x <= result.box_max_x)
                          && (result.box_min_y <= result.box_max_y)
                          && (result.box_min_z <= result.box_max_z);

    `AABB_CHECK_NOW(a_push_has_room, push, !q_stat.full)
    `AABB_CHECK_NOW(a_pop_has_entry, pop, !q_stat.empty)
    `AABB_CHECK_NOW(a_empty_box_zero, result.valid && !result.box_valid, out_box_zero)
    `AABB_CHECK_NOW(a_box_ordered, result.valid && result.box_valid, out_box_ordered)

endmodule

>>> sim/aabb_box_checker.sv
`timescale 1ns / 1ps

module aabb_box_checker
    import aabb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    aabb_item_if   item,
    aabb_result_if result,
    output int     errors,
    output int     pending,
    output int     checked
);

    typedef struct packed {
        coord3_t lo;
        coord3_t hi;
        logic    valid;
        axis_t   longest;
        axis_t   shortest;
    } box_t;

    localparam longint COORD_HI = longint'(COORD_MAX);
    localparam longint COORD_LO = longint'(COORD_MIN);

    longint low_edge [AXES];
    longint high_edge [AXES];
    logic   occupied;
    box_t   box_queue [$];
    int     mismatches = 0;
    int     results_seen = 0;
    int     outstanding = 0;

    assign errors  = mismatches;
    assign pending = outstanding;
    assign checked = results_seen;

    function automatic longint clamp_add(longint a, longint b);
        longint s;
        s = a + b;
        return (s > COORD_HI) ? COORD_HI : s;
    endfunction

    function automatic longint clamp_sub(longint a, longint b);
        longint s;
        s = a - b;
        return (s < COORD_LO) ? COORD_LO : s;
    endfunction

    // Half offset of a disk along one axis: r * (1 - n^2), with n^2 formed exactly.
    function automatic longint disk_half(longint r, longint n);
        longint mag;
        longint factor;
        mag = (n < 0) ? -n : n;
        factor = (longint'(1) << (2 * NFRAC)) - mag * mag;
        return (r * factor) >>> (2 * NFRAC);
    endfunction

    // Strict compares, so ties go to the later axis. Negated extents give the shortest.
    function automatic axis_t extreme_axis(longint d0, longint d1, longint d2);
        if (d0 > d1 && d0 > d2)
            return AXIS_X;
        if (d1 > d2)
            return AXIS_Y;
        return AXIS_Z;
    endfunction

    task automatic clear_box();
        for (int a = 0; a < AXES; a++)
        begin
            low_edge[a]  = 0;
            high_edge[a] = 0;
        end
        occupied = 1'b0;
    endtask

    task automatic report(input string what);
        mismatches++;
        $display("Mismatch at result %0d (t=%0t): %s", results_seen, $time, what);
    endtask

    task automatic absorb_item();
        longint p [AXES];
        longint u [AXES];
        longint n [AXES];
        longint lo [AXES];
        longint hi [AXES];
        longint d [AXES];
        longint r;
        longint h;
        bit     grow;
        box_t   b;
        p[0] = longint'(item.pos_x);
        p[1] = longint'(item.pos_y);
        p[2] = longint'(item.pos_z);
        u[0] = longint'(item.upper_x);
        u[1] = longint'(item.upper_y);
        u[2] = longint'(item.upper_z);
        n[0] = longint'(item.normal_x);
        n[1] = longint'(item.normal_y);
        n[2] = longint'(item.normal_z);
        r = longint'(item.radius);
        grow = 1'b0;
        case (item.command)
            CMD_POINT:
            begin
                lo = p;
                hi = p;
                grow = 1'b1;
            end
            CMD_SPHERE, CMD_DISK:
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    h = (item.command == CMD_SPHERE) ? r : disk_half(r, n[a]);
                    lo[a] = clamp_sub(p[a], h);
                    hi[a] = clamp_add(p[a], h);
                end
                grow = 1'b1;
            end
            CMD_MERGE:
            begin
                // A box with its minimum above its maximum on any axis is dropped.
                if (p[0] <= u[0] && p[1] <= u[1] && p[2] <= u[2])
                begin
                    lo = p;
                    hi = u;
                    grow = 1'b1;
                end
            end
            CMD_CLEAR:
                clear_box();
            default:
                ;
        endcase
        if (grow)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                if (!occupied || lo[a] < low_edge[a])
                    low_edge[a] = lo[a];
                if (!occupied || hi[a] > high_edge[a])
                    high_edge[a] = hi[a];
            end
            occupied = 1'b1;
        end
        for (int a = 0; a < AXES; a++)
        begin
            b.lo[a] = low_edge[a][COORD_BITS-1:0];
            b.hi[a] = high_edge[a][COORD_BITS-1:0];
            d[a] = high_edge[a] - low_edge[a];
        end
        b.valid    = occupied;
        b.longest  = extreme_axis(d[0], d[1], d[2]);
        b.shortest = extreme_axis(-d[0], -d[1], -d[2]);
        box_queue.push_back(b);
    endtask

    task automatic check_result();
        box_t  want;
        box_t  got;
        string axis_names;
        axis_names = "xyz";
        results_seen++;
        got.lo[0]    = result.box_min_x;
        got.lo[1]    = result.box_min_y;
        got.lo[2]    = result.box_min_z;
        got.hi[0]    = result.box_max_x;
        got.hi[1]    = result.box_max_y;
        got.hi[2]    = result.box_max_z;
        got.valid    = result.box_valid;
        got.longest  = result.longest_axis;
        got.shortest = result.shortest_axis;
        if (box_queue.size() == 0)
            report("result arrived with no transaction waiting for it");
        else
        begin
            want = box_queue.pop_front();
            for (int a = 0; a < AXES; a++)
            begin
                if (got.lo[a] !== want.lo[a])
                    report($sformatf("box_min_%c is %h, expected %h",
                                     axis_names[a], got.lo[a], want.lo[a]));
                if (got.hi[a] !== want.hi[a])
                    report($sformatf("box_max_%c is %h, expected %h",
                                     axis_names[a], got.hi[a], want.hi[a]));
            end
            if (got.valid !== want.valid)
                report($sformatf("box_valid is %b, expected %b", got.valid, want.valid));
            if (got.longest !== want.longest)
                report($sformatf("longest_axis is %0d, expected %0d",
                                 got.longest, want.longest));
            if (got.shortest !== want.shortest)
                report($sformatf("shortest_axis is %0d, expected %0d",
                                 got.shortest, want.shortest));
        end
    endtask

    // Results never leave in the cycle their transaction is accepted, so the result side goes first.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_box();
            box_queue.delete();
            outstanding = 0;
        end
        else
        begin
            if (result.valid && result.ready)
                check_result();
            if (item.valid && item.ready)
                absorb_item();
            outstanding = box_queue.size();
        end
    end

endmodule

>>> sim/aabb_accumulator_core_tb.sv
`timescale 1ns / 1ps

module aabb_accumulator_core_tb;
    import aabb_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 925;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD      = 80;
    localparam int MAX_GAP        = 6;

    typedef logic signed [NORMAL_BITS-1:0] normal_t;

    localparam coord_t  UNIT     = coord_t'(1 << 16);
    localparam normal_t NORM_MAX = {1'b0, {(NORMAL_BITS - 1){1'b1}}};
    localparam normal_t NORM_MIN = {1'b1, {(NORMAL_BITS - 1){1'b0}}};
    localparam cmd_t    CMD_LAST = '1;

    typedef struct packed {
        cmd_t                   command;
        coord3_t                pos;
        coord3_t                upper;
        logic [RADIUS_BITS-1:0] radius;
        norm3_t                 normal;
    } item_t;

    logic clk = 1'b0;
    logic rst_n;
    int   error_count;
    int   pending_count;
    int   checked_count;
    int   items_sent = 0;
    int   directed_items = 0;
    int   long_holds = 0;
    int   idle_cycles = 0;

    aabb_item_if   item_ch ();
    aabb_result_if result_ch ();

    aabb_accumulator_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    aabb_box_checker i_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .errors  (error_count),
        .pending (pending_count),
        .checked (checked_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Mix of full-range, near-limit and small coordinates so boxes do not all saturate.
    function automatic coord_t random_coord();
        case ($urandom_range(0, 7))
            0:       return coord_t'($urandom);
            1:       return COORD_MAX - coord_t'($urandom_range(0, 255));
            2:       return COORD_MIN + coord_t'($urandom_range(0, 255));
            default: return coord_t'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    function automatic item_t random_item();
        item_t  t;
        int     pick;
        coord_t held;
        pick = $urandom_range(0, 99);
        if (pick < 24)
            t.command = CMD_POINT;
        else if (pick < 44)
            t.command = CMD_SPHERE;
        else if (pick < 64)
            t.command = CMD_MERGE;
        else if (pick < 88)
            t.command = CMD_DISK;
        else if (pick < 93)
            t.command = CMD_CLEAR;
        else
            t.command = cmd_t'($urandom_range(CMD_CLEAR + 1, CMD_LAST));
        for (int a = 0; a < AXES; a++)
        begin
            t.pos[a]   = random_coord();
            t.upper[a] = random_coord();
            case ($urandom_range(0, 9))
                0:       t.normal[a] = NORM_MAX;
                1:       t.normal[a] = NORM_MIN;
                2:       t.normal[a] = '0;
                default: t.normal[a] = normal_t'($urandom);
            endcase
        end
        if ($urandom_range(0, 3) == 0)
            t.radius = RADIUS_BITS'($urandom);
        else
            t.radius = RADIUS_BITS'($urandom_range(0, 1 << 18));
        // Most merged boxes are well formed; the rest keep their inverted axes.
        if (t.command == CMD_MERGE && $urandom_range(0, 4) != 0)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                if ($signed(t.pos[a]) > $signed(t.upper[a]))
                begin
                    held       = t.pos[a];
                    t.pos[a]   = t.upper[a];
                    t.upper[a] = held;
                end
            end
        end
        return t;
    endfunction

    // Returns at the edge where the transaction is accepted, with valid still high.
    task automatic drive_item(input item_t t, input bit eager);
        int gap;
        gap = eager ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.command  <= t.command;
        item_ch.pos_x    <= t.pos[0];
        item_ch.pos_y    <= t.pos[1];
        item_ch.pos_z    <= t.pos[2];
        item_ch.radius   <= t.radius;
        item_ch.upper_x  <= t.upper[0];
        item_ch.upper_y  <= t.upper[1];
        item_ch.upper_z  <= t.upper[2];
        item_ch.normal_x <= t.normal[0];
        item_ch.normal_y <= t.normal[1];
        item_ch.normal_z <= t.normal[2];
        do
            @(posedge clk);
        while (!item_ch.ready);
        items_sent++;
    endtask

    // Result side: random stalls, stall-free stretches and two long hold-offs.
    initial
    begin
        int stall;
        int rounds;
        rounds = 0;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rounds == 150 || rounds == 450)
            begin
                stall = LONG_HOLD;
                long_holds++;
            end
            else if (rounds % 128 < 24)
                stall = 0;
            else
                stall = $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_ch.valid);
            rounds++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transaction for %0d cycles, %0d results outstanding.",
                     idle_cycles, pending_count);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        item_t t;
        rst_n            = 1'b0;
        item_ch.valid    = 1'b0;
        item_ch.command  = CMD_POINT;
        item_ch.pos_x    = '0;
        item_ch.pos_y    = '0;
        item_ch.pos_z    = '0;
        item_ch.radius   = '0;
        item_ch.upper_x  = '0;
        item_ch.upper_y  = '0;
        item_ch.upper_z  = '0;
        item_ch.normal_x = '0;
        item_ch.normal_y = '0;
        item_ch.normal_z = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First point loads the empty box.
        t = '0;
        t.command = CMD_POINT;
        t.pos[0] = UNIT;
        t.pos[1] = -2 * UNIT;
        t.pos[2] = 3 * UNIT + UNIT / 2;
        drive_item(t, 1'b0);
        t.pos = {AXES{COORD_MIN}};
        drive_item(t, 1'b0);
        t.pos = {AXES{COORD_MAX}};
        drive_item(t, 1'b0);
        t = '0;
        t.command = CMD_CLEAR;
        drive_item(t, 1'b0);

        // Inverted box on an empty box, then a real one, then one already inside.
        t.command = CMD_MERGE;
        t.upper = {AXES{UNIT}};
        t.upper[1] = -UNIT;
        drive_item(t, 1'b0);
        t.upper[0] = 4 * UNIT;
        t.upper[1] = 2 * UNIT;
        t.upper[2] = 2 * UNIT;
        drive_item(t, 1'b0);
        t.pos = {AXES{UNIT}};
        t.upper = {AXES{UNIT}};
        drive_item(t, 1'b0);
        t = '0;
        t.command = CMD_POINT;
        t.pos = {AXES{UNIT}};
        t.pos[1] = 9 * UNIT;
        drive_item(t, 1'b0);
        t.command = CMD_MERGE;
        t.pos = {AXES{-UNIT}};
        t.upper = {AXES{UNIT}};
        t.upper[2] = 20 * UNIT;
        drive_item(t, 1'b0);
        t = '0;
        t.command = CMD_CLEAR;
        drive_item(t, 1'b0);

        // Spheres: zero radius, then saturation at both ends of the range.
        t.command = CMD_SPHERE;
        t.pos[0] = UNIT;
        t.pos[1] = 2 * UNIT;
        t.pos[2] = 3 * UNIT;
        drive_item(t, 1'b0);
        t.pos = {AXES{COORD_MAX}};
        t.radius = '1;
        drive_item(t, 1'b0);
        t = '0;
        t.command = CMD_CLEAR;
        drive_item(t, 1'b0);
        t.command = CMD_SPHERE;
        t.pos = {AXES{COORD_MIN}};
        t.radius = '1;
        drive_item(t, 1'b0);
        t = '0;
        t.command = CMD_CLEAR;
        drive_item(t, 1'b0);

        // Disks: a normal of -1.0 adds nothing, a zero component adds the full radius.
        t.command = CMD_DISK;
        t.radius = '1;
        t.normal[0] = NORM_MIN;
        t.normal[2] = NORM_MAX;
        drive_item(t, 1'b0);
        t.pos = {AXES{5 * UNIT}};
        t.radius = RADIUS_BITS'(3 * UNIT);
        t.normal[0] = NORM_MAX;
        t.normal[1] = NORM_MIN;
        t.normal[2] = normal_t'(NORM_MAX / 2);
        drive_item(t, 1'b0);

        // Unused command codes must leave a populated box alone.
        for (int c = CMD_CLEAR + 1; c <= CMD_LAST; c++)
        begin
            t = random_item();
            t.command = cmd_t'(c);
            drive_item(t, 1'b0);
        end
        t = '0;
        t.command = CMD_MERGE;
        t.pos[0] = 2 * UNIT;
        t.upper = {AXES{UNIT}};
        drive_item(t, 1'b0);
        t = '0;
        t.command = CMD_CLEAR;
        drive_item(t, 1'b0);
        directed_items = items_sent;

        for (int i = 0; i < RANDOM_ITEMS; i++)
            drive_item(random_item(), (i >= 300 && i < 380) || (i >= 650 && i < 700));
        item_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d transactions (%0d directed): all command codes, saturation,",
                 items_sent, directed_items);
        $display("inverted merges and %0d long result stalls; %0d results checked, %0d mismatches.",
                 long_holds, checked_count, error_count);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
